// ----- rtl/bpf_pkg.sv -----
// shared types and defaults for the byte pipe fifo
package bpf_pkg;

  // default sizing
  localparam int unsigned DefaultDepth    = 1024;
  localparam int unsigned DefaultMaxUsers = 15;

  // operation carried by one item
  typedef enum logic [1:0] {
    MODE_WRITE      = 2'd0,
    MODE_READ       = 2'd1,
    MODE_REGISTER   = 2'd2,
    MODE_UNREGISTER = 2'd3
  } bpf_mode_e;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_WOULD_BLOCK = 3'd1,
    STATUS_END_OF_STRM = 3'd2,
    STATUS_NO_READER   = 3'd3,
    STATUS_WAITING     = 3'd4
  } bpf_status_e;

  // memory strobes from control to storage
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } bpf_mem_ctl_t;

endpackage

// ----- rtl/bpf_ram.sv -----
// byte storage with one write port and one registered read port
module bpf_ram #(
  parameter int unsigned DEPTH = bpf_pkg::DefaultDepth,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  bpf_pkg::bpf_mem_ctl_t mem_ctl_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  logic [7:0]            wr_data_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  output logic [7:0]            rd_data_o
);
  import bpf_pkg::*;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/bpf_ctrl.sv -----
// pointer, fill and endpoint count state plus the result register
module bpf_ctrl #(
  parameter int unsigned DEPTH     = bpf_pkg::DefaultDepth,
  parameter int unsigned MAX_USERS = bpf_pkg::DefaultMaxUsers,
  localparam int unsigned AddrW = $clog2(DEPTH),
  localparam int unsigned FillW = $clog2(DEPTH + 1),
  localparam int unsigned UserW = $clog2(MAX_USERS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic                  as_reader_i,
  input  logic                  as_writer_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  got_byte_o,
  output logic [2:0]            status_o,
  output logic [FillW-1:0]      fill_level_o,
  output logic [UserW-1:0]      reader_total_o,
  output logic [UserW-1:0]      writer_total_o,
  output bpf_pkg::bpf_mem_ctl_t mem_ctl_o,
  output logic [AddrW-1:0]      wr_addr_o,
  output logic [AddrW-1:0]      rd_addr_o
);
  import bpf_pkg::*;

  localparam logic [AddrW-1:0] LastIdx = AddrW'(DEPTH - 1);
  localparam logic [FillW-1:0] FullCnt = FillW'(DEPTH);
  localparam logic [UserW-1:0] MaxCnt  = UserW'(MAX_USERS);

  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [FillW-1:0] held_q, held_d;
  logic [UserW-1:0] rcnt_q, rcnt_d;
  logic [UserW-1:0] wcnt_q, wcnt_d;
  logic             out_valid_q;
  logic             got_q, got_d;
  bpf_status_e      status_q, status_d;
  logic             accept;
  bpf_mode_e        mode;

  // a new item enters whenever the result slot is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign mode       = bpf_mode_e'(mode_i);

  // decide the operation outcome
  always_comb begin
    head_d           = head_q;
    tail_d           = tail_q;
    held_d           = held_q;
    rcnt_d           = rcnt_q;
    wcnt_d           = wcnt_q;
    got_d            = 1'b0;
    status_d         = STATUS_OK;
    mem_ctl_o.wr_en  = 1'b0;
    mem_ctl_o.rd_en  = 1'b0;
    unique case (mode)
      MODE_WRITE: begin
        if (held_q != FullCnt) begin
          mem_ctl_o.wr_en = accept;
          tail_d          = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
          held_d          = held_q + 1'b1;
        end else begin
          status_d = (rcnt_q != '0) ? STATUS_WOULD_BLOCK : STATUS_NO_READER;
        end
      end
      MODE_READ: begin
        if (held_q != '0) begin
          mem_ctl_o.rd_en = accept;
          got_d           = 1'b1;
          head_d          = (head_q == LastIdx) ? '0 : head_q + 1'b1;
          held_d          = held_q - 1'b1;
        end else begin
          status_d = (wcnt_q != '0) ? STATUS_WOULD_BLOCK : STATUS_END_OF_STRM;
        end
      end
      MODE_REGISTER: begin
        if (as_reader_i) begin
          rcnt_d = (rcnt_q >= MaxCnt) ? MaxCnt : rcnt_q + 1'b1;
        end
        if (as_writer_i) begin
          wcnt_d = (wcnt_q >= MaxCnt) ? MaxCnt : wcnt_q + 1'b1;
        end
        if (rcnt_d == '0 || wcnt_d == '0) begin
          status_d = STATUS_WAITING;
        end
      end
      MODE_UNREGISTER: begin
        if (as_reader_i && rcnt_q != '0) begin
          rcnt_d = rcnt_q - 1'b1;
        end
        if (as_writer_i && wcnt_q != '0) begin
          wcnt_d = wcnt_q - 1'b1;
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  assign wr_addr_o = tail_q;
  assign rd_addr_o = head_q;

  // pipe state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      held_q <= '0;
      rcnt_q <= '0;
      wcnt_q <= '0;
    end else if (accept) begin
      head_q <= head_d;
      tail_q <= tail_d;
      held_q <= held_d;
      rcnt_q <= rcnt_d;
      wcnt_q <= wcnt_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      got_q          <= got_d;
      status_q       <= status_d;
      fill_level_o   <= held_d;
      reader_total_o <= rcnt_d;
      writer_total_o <= wcnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign got_byte_o  = got_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/byte_pipe_fifo_with_endpoint_counts.sv -----
// top level of the byte pipe fifo with reader and writer endpoint counts
// Each item is one operation (write byte, read byte, register or unregister
// an endpoint) and yields exactly one result item in the cycle after it is
// accepted. One item is taken every cycle unless the output stalls: the
// operation needs at most one slot of the byte store, written at the tail
// or read at the head through a registered read port, and a few counter
// updates, all settled in a single pass into the result register. Input
// ready is high whenever the result register is empty or its item is taken
// in the same cycle, so a stalled output holds the input back. The byte
// store is not cleared at reset; only written slots are ever read.
module byte_pipe_fifo_with_endpoint_counts #(
  parameter int unsigned DEPTH     = bpf_pkg::DefaultDepth,
  parameter int unsigned MAX_USERS = bpf_pkg::DefaultMaxUsers,
  localparam int unsigned FillW = $clog2(DEPTH + 1),
  localparam int unsigned UserW = $clog2(MAX_USERS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       mode_i,
  input  logic [7:0]       data_byte_i,
  input  logic             as_reader_i,
  input  logic             as_writer_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       read_byte_o,
  output logic [2:0]       status_o,
  output logic [FillW-1:0] fill_level_o,
  output logic [UserW-1:0] reader_total_o,
  output logic [UserW-1:0] writer_total_o
);
  import bpf_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);

  bpf_mem_ctl_t     mem_ctl;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             got_byte;

  // control and result register
  bpf_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_USERS (MAX_USERS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .as_reader_i    (as_reader_i),
    .as_writer_i    (as_writer_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .got_byte_o     (got_byte),
    .status_o       (status_o),
    .fill_level_o   (fill_level_o),
    .reader_total_o (reader_total_o),
    .writer_total_o (writer_total_o),
    .mem_ctl_o      (mem_ctl),
    .wr_addr_o      (wr_addr),
    .rd_addr_o      (rd_addr)
  );

  // byte store
  bpf_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (data_byte_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // byte shows only for a successful read
  assign read_byte_o = got_byte ? rd_data : 8'h00;

  // blocking statuses only at the empty or full boundary
  a_block_at_edge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_WOULD_BLOCK
      |-> fill_level_o == '0 || fill_level_o == FillW'(DEPTH))
    else $error("would_block away from empty or full");

  // no reader status needs a full pipe and no readers
  a_no_reader : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_NO_READER
      |-> fill_level_o == FillW'(DEPTH) && reader_total_o == '0)
    else $error("no_reader with readers present or pipe not full");

  // waiting status means one side has no endpoint
  a_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_WAITING
      |-> reader_total_o == '0 || writer_total_o == '0)
    else $error("waiting_for_partner with both sides registered");

  // counts stay within their limits
  a_limits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_level_o <= FillW'(DEPTH)
      && reader_total_o <= UserW'(MAX_USERS) && writer_total_o <= UserW'(MAX_USERS))
    else $error("fill or endpoint count beyond its limit");

endmodule

// ----- tb/sv/tb_byte_pipe_fifo_with_endpoint_counts.sv -----
// testbench for the byte pipe fifo with reader and writer endpoint counts
`timescale 1ns / 1ps

module tb_byte_pipe_fifo_with_endpoint_counts;
  import bpf_pkg::*;

  localparam int unsigned PipeDepth  = DefaultDepth;
  localparam int unsigned MaxUsers   = DefaultMaxUsers;
  localparam int unsigned FillW      = $clog2(PipeDepth + 1);
  localparam int unsigned UserW      = $clog2(MaxUsers + 1);
  localparam int unsigned SlotW      = $clog2(PipeDepth);
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned HoldCycles = 120;

  // one operation offered to the pipe
  typedef struct {
    bpf_mode_e   mode;
    logic [7:0]  data_byte;
    logic        as_reader;
    logic        as_writer;
    int unsigned gap;
    bit          wait_idle;
  } pipe_op_t;

  // one result the pipe should return
  typedef struct {
    logic [7:0]       read_byte;
    bpf_status_e      status;
    logic [FillW-1:0] fill_level;
    logic [UserW-1:0] reader_total;
    logic [UserW-1:0] writer_total;
  } pipe_result_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode_i = '0;
  logic [7:0] data_byte_i = '0;
  logic as_reader_i = 1'b0;
  logic as_writer_i = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] read_byte_o;
  logic [2:0] status_o;
  logic [FillW-1:0] fill_level_o;
  logic [UserW-1:0] reader_total_o;
  logic [UserW-1:0] writer_total_o;

  // pipe state as predicted
  logic [7:0]       pipe_bytes [PipeDepth];
  logic [SlotW-1:0] head_slot = '0;
  logic [SlotW-1:0] tail_slot = '0;
  logic [FillW-1:0] held_bytes = '0;
  logic [UserW-1:0] reader_cnt = '0;
  logic [UserW-1:0] writer_cnt = '0;

  pipe_op_t     op_queue[$];
  pipe_result_t pending_results[$];

  int unsigned errors = 0;
  int unsigned ops_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mode_tally [4] = '{default: 0};
  int unsigned status_tally [5] = '{default: 0};
  int unsigned peak_fill = 0;

  // stimulus build state
  int unsigned gen_count = 0;
  bit gen_quiet = 1'b0;
  bit gen_drain = 1'b0;

  // driver state
  pipe_op_t    drv_item;
  bit          drv_loaded = 1'b0;
  bit          drv_valid;
  int unsigned drv_gap = 0;
  int unsigned drv_taken = 0;

  // receiver state
  int unsigned rx_taken = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_hold = 0;
  bit          rx_quiet = 1'b0;

  byte_pipe_fifo_with_endpoint_counts i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .as_reader_i    (as_reader_i),
    .as_writer_i    (as_writer_i),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_byte_o    (read_byte_o),
    .status_o       (status_o),
    .fill_level_o   (fill_level_o),
    .reader_total_o (reader_total_o),
    .writer_total_o (writer_total_o)
  );

  always #10 clk = ~clk;

  // advance a circular slot index
  function automatic logic [SlotW-1:0] next_slot(logic [SlotW-1:0] slot);
    return (slot == SlotW'(PipeDepth - 1)) ? '0 : slot + 1'b1;
  endfunction

  // apply one operation to the predicted pipe and return its result
  function automatic pipe_result_t apply_pipe_op(pipe_op_t op);
    pipe_result_t res;
    res.read_byte = 8'h00;
    res.status = STATUS_OK;
    case (op.mode)
      MODE_WRITE: begin
        if (held_bytes < FillW'(PipeDepth)) begin
          pipe_bytes[tail_slot] = op.data_byte;
          tail_slot = next_slot(tail_slot);
          held_bytes = held_bytes + 1'b1;
        end else begin
          res.status = (reader_cnt != 0) ? STATUS_WOULD_BLOCK : STATUS_NO_READER;
        end
      end
      MODE_READ: begin
        if (held_bytes != 0) begin
          res.read_byte = pipe_bytes[head_slot];
          head_slot = next_slot(head_slot);
          held_bytes = held_bytes - 1'b1;
        end else begin
          res.status = (writer_cnt != 0) ? STATUS_WOULD_BLOCK : STATUS_END_OF_STRM;
        end
      end
      MODE_REGISTER: begin
        if (op.as_reader && reader_cnt != UserW'(MaxUsers)) reader_cnt = reader_cnt + 1'b1;
        if (op.as_writer && writer_cnt != UserW'(MaxUsers)) writer_cnt = writer_cnt + 1'b1;
        if (reader_cnt == 0 || writer_cnt == 0) res.status = STATUS_WAITING;
      end
      default: begin
        if (op.as_reader && reader_cnt != 0) reader_cnt = reader_cnt - 1'b1;
        if (op.as_writer && writer_cnt != 0) writer_cnt = writer_cnt - 1'b1;
      end
    endcase
    res.fill_level = held_bytes;
    res.reader_total = reader_cnt;
    res.writer_total = writer_cnt;
    return res;
  endfunction

  // compare one result field
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
               $time, name, results_seen, want, got);
    end
  endtask

  // queue one operation with a sender gap drawn for it
  task automatic push_op(bpf_mode_e mode, logic [7:0] b, logic rd, logic wr);
    pipe_op_t op;
    if (gen_count % 40 == 0) gen_quiet = ($urandom_range(0, 3) == 0);
    op.mode = mode;
    op.data_byte = b;
    op.as_reader = rd;
    op.as_writer = wr;
    op.gap = gen_quiet ? 0 : $urandom_range(0, 14);
    op.wait_idle = gen_drain;
    gen_drain = 1'b0;
    gen_count++;
    op_queue.push_back(op);
  endtask

  // queue one random operation picked by weight
  task automatic push_random_op(int unsigned w_wr, int unsigned w_rd, int unsigned w_reg,
                                int unsigned w_unreg);
    int unsigned pick;
    bpf_mode_e mode;
    pick = $urandom_range(1, w_wr + w_rd + w_reg + w_unreg);
    if (pick <= w_wr) mode = MODE_WRITE;
    else if (pick <= w_wr + w_rd) mode = MODE_READ;
    else if (pick <= w_wr + w_rd + w_reg) mode = MODE_REGISTER;
    else mode = MODE_UNREGISTER;
    push_op(mode, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // sender: one item at a time, optional gap and wait for an idle pipe
  always @(negedge clk) begin
    if (rst_ni) begin
      drv_valid = in_valid;
      if (in_valid && ops_accepted != drv_taken) begin
        drv_taken = ops_accepted;
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (!drv_loaded && op_queue.size() != 0) begin
          drv_item = op_queue.pop_front();
          drv_loaded = 1'b1;
          drv_gap = drv_item.gap;
        end
        if (drv_loaded) begin
          if (drv_gap != 0) begin
            drv_gap--;
          end else if (!drv_item.wait_idle || pending_results.size() == 0) begin
            mode_i <= drv_item.mode;
            data_byte_i <= drv_item.data_byte;
            as_reader_i <= drv_item.as_reader;
            as_writer_i <= drv_item.as_writer;
            drv_valid = 1'b1;
            drv_loaded = 1'b0;
          end
        end
      end
      in_valid <= drv_valid;
    end
  end

  // receiver: random stall per result, two long hold-offs
  always @(negedge clk) begin
    if (rst_ni) begin
      if (results_seen != rx_taken) begin
        rx_taken = results_seen;
        if (rx_taken % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        rx_stall = rx_quiet ? 0 : $urandom_range(0, 14);
        if (rx_taken == 300 || rx_taken == 1500) rx_hold = HoldCycles;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: check results, predict accepted items
  always @(posedge clk) begin
    pipe_op_t     seen_op;
    pipe_result_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (status_o < 3'd5) status_tally[status_o]++;
        if (fill_level_o > peak_fill) peak_fill = fill_level_o;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: read_byte %0d status %0d fill %0d",
                   $time, read_byte_o, status_o, fill_level_o);
        end else begin
          want = pending_results.pop_front();
          check_field("read_byte", want.read_byte, read_byte_o);
          check_field("status", want.status, status_o);
          check_field("fill_level", want.fill_level, fill_level_o);
          check_field("reader_total", want.reader_total, reader_total_o);
          check_field("writer_total", want.writer_total, writer_total_o);
        end
      end
      if (in_valid && in_ready) begin
        ops_accepted++;
        seen_op.mode = bpf_mode_e'(mode_i);
        seen_op.data_byte = data_byte_i;
        seen_op.as_reader = as_reader_i;
        seen_op.as_writer = as_writer_i;
        seen_op.gap = 0;
        seen_op.wait_idle = 1'b0;
        mode_tally[mode_i]++;
        pending_results.push_back(apply_pipe_op(seen_op));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == StallLimit) begin
          $display("%0t: no handshake for %0d cycles", $time, StallLimit);
          $display("tb_byte_pipe_fifo_with_endpoint_counts: FAIL");
          $finish;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    // empty pipe, endpoint bookkeeping and a few bytes through
    push_op(MODE_READ, 8'h3C, 1'b1, 1'b1);
    push_op(MODE_UNREGISTER, 8'h00, 1'b1, 1'b1);
    push_op(MODE_REGISTER, 8'h00, 1'b0, 1'b0);
    push_op(MODE_REGISTER, 8'h00, 1'b1, 1'b0);
    push_op(MODE_READ, 8'h00, 1'b0, 1'b0);
    push_op(MODE_REGISTER, 8'h00, 1'b0, 1'b1);
    push_op(MODE_READ, 8'hFF, 1'b0, 1'b1);
    push_op(MODE_WRITE, 8'h00, 1'b0, 1'b0);
    push_op(MODE_WRITE, 8'hFF, 1'b1, 1'b1);
    push_op(MODE_WRITE, 8'hA5, 1'b0, 1'b1);
    push_op(MODE_READ, 8'h00, 1'b1, 1'b0);
    push_op(MODE_READ, 8'h00, 1'b0, 1'b0);
    push_op(MODE_REGISTER, 8'h00, 1'b1, 1'b1);
    push_op(MODE_UNREGISTER, 8'h00, 1'b1, 1'b0);
    push_op(MODE_UNREGISTER, 8'h00, 1'b0, 1'b1);
    push_op(MODE_UNREGISTER, 8'h00, 1'b1, 1'b1);
    push_op(MODE_READ, 8'h00, 1'b0, 1'b0);
    push_op(MODE_READ, 8'h00, 1'b0, 1'b0);
    push_op(MODE_REGISTER, 8'hFF, 1'b0, 1'b0);
    push_op(MODE_REGISTER, 8'h00, 1'b1, 1'b1);
    push_op(MODE_WRITE, 8'h5A, 1'b0, 1'b0);
    push_op(MODE_UNREGISTER, 8'h00, 1'b1, 1'b1);
    push_op(MODE_READ, 8'h00, 1'b0, 1'b0);

    // endpoint counts up to saturation, back to zero, then light traffic
    gen_drain = 1'b1;
    repeat (40) push_random_op(1, 1, 9, 1);
    repeat (40) push_random_op(1, 1, 1, 9);
    repeat (100) push_random_op(4, 4, 1, 1);

    // fill until full, tail wraps
    gen_drain = 1'b1;
    repeat (1100) push_random_op(58, 0, 1, 1);
    // writes at full while readers leave and return
    for (int i = 0; i < 15; i++) begin
      push_op(MODE_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
      push_op(MODE_UNREGISTER, 8'($urandom), 1'b1, 1'($urandom));
    end
    for (int i = 0; i < 15; i++) begin
      push_op(MODE_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
      push_op(MODE_REGISTER, 8'($urandom), 1'b1, 1'($urandom));
    end

    // read back part of the full pipe
    gen_drain = 1'b1;
    repeat (260) push_random_op(0, 58, 1, 1);

    // everything mixed
    gen_drain = 1'b1;
    repeat (120) push_random_op(3, 3, 2, 2);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // wait for every item to go in and every result to come back
    do begin
      @(posedge clk);
      #1;
    end while (op_queue.size() != 0 || drv_loaded || in_valid || pending_results.size() != 0);
    repeat (10) @(posedge clk);
    #1;

    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("ran %0d ops (write %0d, read %0d, register %0d, unregister %0d), peak fill %0d",
             ops_accepted, mode_tally[MODE_WRITE], mode_tally[MODE_READ],
             mode_tally[MODE_REGISTER], mode_tally[MODE_UNREGISTER], peak_fill);
    $display("statuses: ok %0d, would_block %0d, end_of_stream %0d, no_reader %0d, waiting %0d",
             status_tally[STATUS_OK], status_tally[STATUS_WOULD_BLOCK],
             status_tally[STATUS_END_OF_STRM], status_tally[STATUS_NO_READER],
             status_tally[STATUS_WAITING]);
    if (errors == 0) begin
      $display("tb_byte_pipe_fifo_with_endpoint_counts: PASS");
    end else begin
      $display("tb_byte_pipe_fifo_with_endpoint_counts: FAIL");
    end
    $finish;
  end

endmodule

// ----- byte_pipe_fifo_with_endpoint_counts.f -----
rtl/bpf_pkg.sv
rtl/bpf_ram.sv
rtl/bpf_ctrl.sv
rtl/byte_pipe_fifo_with_endpoint_counts.sv
tb/sv/tb_byte_pipe_fifo_with_endpoint_counts.sv
